// ----- hdl/bawss_pkg.sv -----
// shared types and constants for the binned arrival window statistics block
package bawss_pkg;

  localparam int DIV_W = 64;
  localparam int WIN_W = 17;
  localparam int BCNT_W = 7;
  localparam int WIDTH_W = 37;
  localparam int CNT_ACC_W = 39;
  localparam int SUM_W = 56;
  localparam int SUM_ACC_W = 63;
  localparam int OUT_W = 48;
  localparam int MUL_W = 59;

  localparam logic [WIN_W-1:0] WINDOW_LIMIT = 17'd86400;
  localparam logic [19:0] US_PER_SECOND = 20'd1000000;
  localparam logic [26:0] ScaleMinute = 27'd60000;
  localparam logic [26:0] ScaleHour = 27'd3600000;
  localparam logic [26:0] ScaleDay = 27'd86400000;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [SUM_W-1:0] MAX56 = {SUM_W{1'b1}};
  localparam logic [OUT_W-1:0] MAX48 = {OUT_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_READ,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    JOB_WIDTH,
    JOB_EPOCH,
    JOB_SLOT,
    JOB_AVG,
    JOB_RMIN,
    JOB_RHOUR,
    JOB_RDAY
  } div_job_t;

  typedef struct packed {
    logic     item_load;
    logic     div_start;
    logic     div_cap;
    div_job_t job;
    logic     rd_slot;
    logic     upd_wr;
    logic     scan_clr;
    logic     scan_rd;
    logic     mul_en;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic seen;
  } dp_status_t;

  typedef struct packed {
    logic             win_we;
    logic             bins_we;
    logic [WIN_W-1:0] data;
  } cfg_wr_t;

endpackage

// ----- hdl/bawss_div.sv -----
// restoring divider, one quotient bit per cycle
module bawss_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bawss_pkg::DIV_W-1:0] dividend,
  input  logic [bawss_pkg::DIV_W-1:0] divisor,
  output logic [bawss_pkg::DIV_W-1:0] quot,
  output logic [bawss_pkg::DIV_W-1:0] rem,
  output logic                      done
);
  import bawss_pkg::*;

  logic [DIV_W-1:0] q;
  logic [DIV_W-1:0] r;
  logic [DIV_W-1:0] d;
  logic [6:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   rs;
  logic             ge;

  assign rs = {r, q[DIV_W-1]};
  assign ge = rs >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      if (ge) begin
        r <= DIV_W'(rs - {1'b0, d});
        q <= {q[DIV_W-2:0], 1'b1};
      end else begin
        r <= rs[DIV_W-1:0];
        q <= {q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
  assign rem = r;

endmodule

// ----- hdl/bawss_ctrl.sv -----
// controller state machine sequencing one arrival through the datapath
module bawss_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bawss_pkg::dp_status_t  status,
  output bawss_pkg::ctrl_cmd_t   cmd
);
  import bawss_pkg::*;

  ctrl_state_t state, state_next;
  div_job_t    job, job_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job <= JOB_WIDTH;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      job <= job_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next = job;
    cmd = '0;
    cmd.job = job;
    in_ready = (state == ST_IDLE);
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          job_next = JOB_WIDTH;
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_cap = 1'b1;
          case (job)
            JOB_WIDTH: begin
              job_next = JOB_EPOCH;
              state_next = ST_DIV_GO;
            end
            JOB_EPOCH: begin
              job_next = JOB_SLOT;
              state_next = ST_DIV_GO;
            end
            JOB_SLOT: state_next = ST_READ;
            JOB_AVG: begin
              job_next = JOB_RMIN;
              state_next = ST_MUL;
            end
            JOB_RMIN: begin
              job_next = JOB_RHOUR;
              state_next = ST_MUL;
            end
            JOB_RHOUR: begin
              job_next = JOB_RDAY;
              state_next = ST_MUL;
            end
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_slot = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.upd_wr = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.seen) begin
          job_next = JOB_AVG;
          state_next = ST_DIV_GO;
        end else begin
          job_next = JOB_RMIN;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_DIV_GO;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/bawss_dp.sv -----
// datapath: config, bin memory, bin update, window scan and result arithmetic
module bawss_dp #(
  parameter int MAX_BINS = 64,
  parameter int TIME_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bawss_pkg::cfg_wr_t            cfg_wr,
  output logic [bawss_pkg::WIN_W-1:0]   window_reg,
  output logic [bawss_pkg::BCNT_W-1:0]  bins_reg,
  input  logic [TIME_WIDTH-1:0]         arrival_time_us,
  input  bawss_pkg::ctrl_cmd_t          cmd,
  output bawss_pkg::dp_status_t         status,
  output logic [31:0]                   arrival_count,
  output logic                          gap_seen,
  output logic [bawss_pkg::OUT_W-1:0]   shortest_gap_us,
  output logic [bawss_pkg::OUT_W-1:0]   longest_gap_us,
  output logic [bawss_pkg::OUT_W-1:0]   avg_gap_us,
  output logic [bawss_pkg::OUT_W-1:0]   rate_per_minute_milli,
  output logic [bawss_pkg::OUT_W-1:0]   rate_per_hour_milli,
  output logic [bawss_pkg::OUT_W-1:0]   rate_per_day_milli
);
  import bawss_pkg::*;

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CMP_W = (IDX_W > BCNT_W) ? IDX_W : BCNT_W;
  localparam int TW = TIME_WIDTH;

  // config and derived values
  logic [WIN_W-1:0]  win_used;
  logic [BCNT_W-1:0] bins_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg <= 17'd60;
      bins_reg <= 7'd60;
    end else begin
      if (cfg_wr.win_we) window_reg <= cfg_wr.data;
      if (cfg_wr.bins_we) bins_reg <= cfg_wr.data[BCNT_W-1:0];
    end
  end

  always_comb begin
    if (window_reg == '0) win_used = 17'd1;
    else if (window_reg > WINDOW_LIMIT) win_used = WINDOW_LIMIT;
    else win_used = window_reg;
    if (bins_reg == '0) bins_used = 7'd1;
    else if (32'(bins_reg) > 32'(MAX_BINS)) bins_used = BCNT_W'(MAX_BINS);
    else bins_used = bins_reg;
  end

  // bin memories
  logic [TW-1:0]    mem_epoch [MAX_BINS];
  logic [31:0]      mem_arr   [MAX_BINS];
  logic [31:0]      mem_gaps  [MAX_BINS];
  logic [SUM_W-1:0] mem_sum   [MAX_BINS];
  logic [TW-1:0]    mem_min   [MAX_BINS];
  logic [TW-1:0]    mem_max   [MAX_BINS];
  logic [MAX_BINS-1:0] bin_valid;

  logic [TW-1:0]    rd_epoch, rd_min, rd_max;
  logic [31:0]      rd_arr, rd_gaps;
  logic [SUM_W-1:0] rd_sum;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  logic [TW-1:0]    wr_epoch, wr_min, wr_max;
  logic [31:0]      wr_arr, wr_gaps;
  logic [SUM_W-1:0] wr_sum;

  // item registers
  logic [TW-1:0]      now_r;
  logic [WIDTH_W-1:0] width_r;
  logic [TW-1:0]      cur_r;
  logic [IDX_W-1:0]   slot_r;
  logic               have_prev;
  logic [TW-1:0]      prev_time;

  // scan registers
  logic [IDX_W-1:0]     scan_idx;
  logic                 acc_pending;
  logic [IDX_W-1:0]     acc_idx;
  logic [CNT_ACC_W-1:0] count_acc;
  logic [CNT_ACC_W-1:0] gcount_acc;
  logic [SUM_ACC_W-1:0] gsum_acc;
  logic [TW-1:0]        gmin, gmax;
  logic                 seen;

  logic [MUL_W-1:0]  mul_q;
  logic [OUT_W-1:0]  avg_r, rmin_r, rhour_r, rday_r;
  logic [31:0]       count_sat;

  // divider
  logic [DIV_W-1:0] div_a, div_b, div_q, div_r;
  logic             div_done;
  logic [DIV_W-1:0] quot_sat_src;
  logic [OUT_W-1:0] quot_sat;

  bawss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  always_comb begin
    case (cmd.job)
      JOB_WIDTH: begin
        div_a = DIV_W'(WIDTH_W'(win_used) * WIDTH_W'(US_PER_SECOND));
        div_b = DIV_W'(bins_used);
      end
      JOB_EPOCH: begin
        div_a = DIV_W'(now_r);
        div_b = DIV_W'(width_r);
      end
      JOB_SLOT: begin
        div_a = DIV_W'(cur_r);
        div_b = DIV_W'(bins_used);
      end
      JOB_AVG: begin
        div_a = DIV_W'(gsum_acc);
        div_b = DIV_W'(gcount_acc);
      end
      default: begin
        div_a = DIV_W'(mul_q);
        div_b = DIV_W'(win_used);
      end
    endcase
  end

  assign quot_sat_src = div_q;
  assign quot_sat = (quot_sat_src > DIV_W'(MAX48)) ? MAX48 : quot_sat_src[OUT_W-1:0];

  // memory port
  assign rd_en = cmd.rd_slot | cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? scan_idx : slot_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_epoch <= mem_epoch[rd_addr];
      rd_arr <= mem_arr[rd_addr];
      rd_gaps <= mem_gaps[rd_addr];
      rd_sum <= mem_sum[rd_addr];
      rd_min <= mem_min[rd_addr];
      rd_max <= mem_max[rd_addr];
    end
    if (cmd.upd_wr) begin
      mem_epoch[slot_r] <= wr_epoch;
      mem_arr[slot_r] <= wr_arr;
      mem_gaps[slot_r] <= wr_gaps;
      mem_sum[slot_r] <= wr_sum;
      mem_min[slot_r] <= wr_min;
      mem_max[slot_r] <= wr_max;
    end
  end

  // bin update
  logic             hit;
  logic [31:0]      base_arr, base_gaps;
  logic [SUM_W-1:0] base_sum;
  logic [TW-1:0]    base_min, base_max, gap;
  logic [TW:0]      sum_ext_lo;
  logic [64:0]      sum_ext;

  always_comb begin
    hit = bin_valid[slot_r] && (rd_epoch == cur_r);
    base_arr = hit ? rd_arr : '0;
    base_gaps = hit ? rd_gaps : '0;
    base_sum = hit ? rd_sum : '0;
    base_min = hit ? rd_min : '0;
    base_max = hit ? rd_max : '0;
    gap = (now_r >= prev_time) ? (now_r - prev_time) : '0;
    sum_ext_lo = {1'b0, gap};
    sum_ext = 65'(base_sum) + 65'(sum_ext_lo);
    wr_epoch = cur_r;
    wr_arr = (base_arr < MAX32) ? base_arr + 32'd1 : base_arr;
    wr_gaps = base_gaps;
    wr_sum = base_sum;
    wr_min = base_min;
    wr_max = base_max;
    if (have_prev) begin
      if (base_gaps == '0 || gap < base_min) wr_min = gap;
      if (gap > base_max) wr_max = gap;
      wr_sum = (sum_ext > 65'(MAX56)) ? MAX56 : sum_ext[SUM_W-1:0];
      if (base_gaps < MAX32) wr_gaps = base_gaps + 32'd1;
    end
  end

  // window scan
  logic live;
  always_comb begin
    live = bin_valid[acc_idx] && (rd_epoch <= cur_r) &&
           ((cur_r - rd_epoch) < TW'(bins_used));
  end

  assign count_sat = (count_acc > CNT_ACC_W'(MAX32)) ? MAX32 : count_acc[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      have_prev <= 1'b0;
      acc_pending <= 1'b0;
    end else begin
      acc_pending <= cmd.scan_rd;
      if (cfg_wr.win_we || cfg_wr.bins_we) begin
        bin_valid <= '0;
        have_prev <= 1'b0;
      end else if (cmd.upd_wr) begin
        bin_valid[slot_r] <= 1'b1;
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr.win_we || cfg_wr.bins_we) prev_time <= '0;
    else if (cmd.upd_wr) prev_time <= now_r;
    if (cmd.item_load) now_r <= arrival_time_us;
    acc_idx <= scan_idx;
    if (cmd.div_cap) begin
      case (cmd.job)
        JOB_WIDTH: width_r <= (div_q == '0) ? WIDTH_W'(1) : div_q[WIDTH_W-1:0];
        JOB_EPOCH: cur_r <= div_q[TW-1:0];
        JOB_SLOT:  slot_r <= div_r[IDX_W-1:0];
        JOB_AVG:   avg_r <= quot_sat;
        JOB_RMIN:  rmin_r <= quot_sat;
        JOB_RHOUR: rhour_r <= quot_sat;
        default:   rday_r <= quot_sat;
      endcase
    end
    if (cmd.mul_en) begin
      case (cmd.job)
        JOB_RMIN:  mul_q <= MUL_W'(count_sat) * MUL_W'(ScaleMinute);
        JOB_RHOUR: mul_q <= MUL_W'(count_sat) * MUL_W'(ScaleHour);
        default:   mul_q <= MUL_W'(count_sat) * MUL_W'(ScaleDay);
      endcase
    end
    if (cmd.scan_clr) begin
      scan_idx <= '0;
      count_acc <= '0;
      gcount_acc <= '0;
      gsum_acc <= '0;
      gmin <= '0;
      gmax <= '0;
      seen <= 1'b0;
      avg_r <= '0;
    end else begin
      if (cmd.scan_rd) scan_idx <= scan_idx + IDX_W'(1);
      if (acc_pending && live) begin
        count_acc <= count_acc + CNT_ACC_W'(rd_arr);
        if (rd_gaps != '0) begin
          gcount_acc <= gcount_acc + CNT_ACC_W'(rd_gaps);
          gsum_acc <= gsum_acc + SUM_ACC_W'(rd_sum);
          if (!seen || rd_min < gmin) gmin <= rd_min;
          if (!seen || rd_max > gmax) gmax <= rd_max;
          seen <= 1'b1;
        end
      end
    end
    if (cmd.load_out) begin
      arrival_count <= count_sat;
      gap_seen <= seen;
      shortest_gap_us <= OUT_W'(gmin);
      longest_gap_us <= OUT_W'(gmax);
      avg_gap_us <= avg_r;
      rate_per_minute_milli <= rmin_r;
      rate_per_hour_milli <= rhour_r;
      rate_per_day_milli <= rday_r;
    end
  end

  assign status.div_done = div_done;
  assign status.scan_last = (CMP_W'(scan_idx) == CMP_W'(bins_used - 7'd1));
  // include the last bin, still being folded in during the drain cycle
  assign status.seen = seen | (acc_pending & live & (rd_gaps != '0));

endmodule

// ----- hdl/binned_arrival_window_stats.sv -----
// top level of the binned arrival window statistics block
// each arrival runs six divisions, a seventh for the average when gaps are live; all
//   divisions share the one bit-serial divider
// one arrival at a time: the next transfer is taken in the cycle after the result loads
// the next arrival is taken while the previous result still waits in the output register
// reset (synchronous, active high): window 60 s, 60 bins, all bins invalid, no previous
//   arrival; a config write clears the ring at once, no clearing pass
module binned_arrival_window_stats #(
  parameter int MAX_BINS = 64,
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  // config port, pready always high
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // arrival input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_WIDTH-1:0] arrival_time_us,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           arrival_count,
  output logic                  gap_seen,
  output logic [47:0]           shortest_gap_us,
  output logic [47:0]           longest_gap_us,
  output logic [47:0]           avg_gap_us,
  output logic [47:0]           rate_per_minute_milli,
  output logic [47:0]           rate_per_hour_milli,
  output logic [47:0]           rate_per_day_milli
);
  import bawss_pkg::*;

  cfg_wr_t           cfg_wr;
  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [WIN_W-1:0]  window_reg;
  logic [BCNT_W-1:0] bins_reg;
  logic              wr_xfer;

  // write transfer completes in the access phase
  assign pready = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;
  assign cfg_wr.win_we = wr_xfer && !paddr[2];
  assign cfg_wr.bins_we = wr_xfer && paddr[2];
  assign cfg_wr.data = pwdata[WIN_W-1:0];

  // register readback, window at 0, bin count at 4
  assign prdata = paddr[2] ? {25'd0, bins_reg} : {15'd0, window_reg};

  bawss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bawss_dp #(
    .MAX_BINS   (MAX_BINS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_wr                (cfg_wr),
    .window_reg            (window_reg),
    .bins_reg              (bins_reg),
    .arrival_time_us       (arrival_time_us),
    .cmd                   (cmd),
    .status                (status),
    .arrival_count         (arrival_count),
    .gap_seen              (gap_seen),
    .shortest_gap_us       (shortest_gap_us),
    .longest_gap_us        (longest_gap_us),
    .avg_gap_us            (avg_gap_us),
    .rate_per_minute_milli (rate_per_minute_milli),
    .rate_per_hour_milli   (rate_per_hour_milli),
    .rate_per_day_milli    (rate_per_day_milli)
  );

endmodule
